[rtl/core/i2cseq_pkg.sv]
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and constants for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	// Request kinds on the request channel.
	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_START = 2'd1,
		REQ_EVENT = 2'd2,
		REQ_READ  = 2'd3
	} req_kind_t;

	// Transfer status reported with every response.
	typedef enum logic [2:0] {
		XS_PENDING = 3'd0,
		XS_SUCCESS = 3'd1,
		XS_AW_NACK = 3'd2,
		XS_AR_NACK = 3'd3,
		XS_D_NACK  = 3'd4,
		XS_BUS_ERR = 3'd5,
		XS_OTHER   = 3'd6
	} xfer_status_t;

	// Bus status codes, low two bits masked off.
	localparam logic [7:0] ST_MASK        = 8'hFC;
	localparam logic [7:0] ST_BUS_ERR     = 8'h00;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_REP_START   = 8'h10;
	localparam logic [7:0] ST_MTX_ADR_ACK = 8'h18;
	localparam logic [7:0] ST_MTX_ADR_NAK = 8'h20;
	localparam logic [7:0] ST_MTX_DAT_ACK = 8'h28;
	localparam logic [7:0] ST_MTX_DAT_NAK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST    = 8'h38;
	localparam logic [7:0] ST_MRX_ADR_ACK = 8'h40;
	localparam logic [7:0] ST_MRX_ADR_NAK = 8'h48;
	localparam logic [7:0] ST_MRX_DAT_ACK = 8'h50;
	localparam logic [7:0] ST_MRX_DAT_NAK = 8'h58;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] buf_index;
		logic [7:0] buf_data;
		logic [3:0] msg_length;
		logic [7:0] bus_status;
		logic [7:0] rx_byte;
	} req_payload_t;

	typedef struct packed {
		logic       cmd_valid;
		logic       cmd_start;
		logic       cmd_stop;
		logic       cmd_ack;
		logic       cmd_clear_flag;
		logic       tx_load;
		logic [7:0] tx_byte;
		logic [2:0] xfer_status;
		logic       busy_res;
		logic [7:0] read_data;
	} rsp_payload_t;

endpackage

[rtl/core/i2cseq_req_if.sv]
// ----------------------------------------------------------------------------
// i2cseq_req_if
// Valid/ready request channel of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
interface i2cseq_req_if;
	import i2cseq_pkg::*;

	logic         valid;
	logic         ready;
	req_payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/i2cseq_rsp_if.sv]
// ----------------------------------------------------------------------------
// i2cseq_rsp_if
// Valid/ready response channel of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
interface i2cseq_rsp_if;
	import i2cseq_pkg::*;

	logic         valid;
	logic         ready;
	rsp_payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/i2c_master_transfer_sequencer_core.sv]
// A request's response is presented in the cycle after its transfer is accepted.
// Throughput: one request per cycle unless the sink stalls; the single response register
// is refilled in the same cycle it is emptied; one buffer read port per cycle suffices.
// Reset clears the byte pointer, length, status and active flag; the buffer is not cleared.
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// Interrupt-driven I2C master transfer sequencer with a message byte buffer.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core #(
	parameter int BUF_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	i2cseq_req_if.sink          req,
	i2cseq_rsp_if.source        rsp
);
	import i2cseq_pkg::*;

	// Address width of the buffer, width of the pointer (it saturates at
	// BUF_DEPTH, so it needs one more code), and a widened request index.
	localparam int AW = $clog2(BUF_DEPTH);
	localparam int PW = $clog2(BUF_DEPTH + 1);
	localparam int IW = (AW > 3) ? AW : 3;
	localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);

	// The message buffer lives in a synchronous memory. All control state
	// is small and kept in flops so that each event can see the result of
	// the one before it without waiting for the memory.
	logic [7:0]    mem [BUF_DEPTH];
	logic [7:0]    rdata_s1;

	logic [PW-1:0] ptr_q, ptr_d;
	logic [PW-1:0] len_q, len_d;
	xfer_status_t  status_q, status_d;
	logic          active_q, active_d;

	// Response register. tx_byte and read_data come from the registered
	// memory read data, selected by these two flags.
	logic          rsp_valid_q;
	logic          cmd_valid_s1, cmd_start_s1, cmd_stop_s1, cmd_ack_s1, cmd_clr_s1;
	logic          tx_load_s1, rd_sel_s1;

	logic          cmd_valid, cmd_start, cmd_stop, cmd_ack, cmd_clr;
	logic          tx_load, rd_sel;
	logic          acc;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;

	logic [7:0]    stat;
	logic [IW-1:0] idx_ext;
	logic [AW-1:0] idx_addr;
	logic          idx_ok;
	logic [PW-1:0] p;
	logic [PW:0]   p_inc;
	req_kind_t     kind;

	// The response register frees up in the same cycle its transfer
	// completes, so a stalled sink is the only thing that holds requests.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	assign kind     = req_kind_t'(req.data.req_type);
	assign stat     = req.data.bus_status & ST_MASK;
	assign idx_ext  = IW'(req.data.buf_index);
	assign idx_addr = idx_ext[AW-1:0];
	assign idx_ok   = int'(req.data.buf_index) < BUF_DEPTH;

	always_comb begin
		ptr_d     = ptr_q;
		len_d     = len_q;
		status_d  = status_q;
		active_d  = active_q;
		cmd_valid = 1'b0;
		cmd_start = 1'b0;
		cmd_stop  = 1'b0;
		cmd_ack   = 1'b0;
		cmd_clr   = 1'b0;
		tx_load   = 1'b0;
		rd_sel    = 1'b0;
		we        = 1'b0;
		waddr     = idx_addr;
		wdata     = req.data.buf_data;
		raddr     = idx_addr;
		p         = ptr_q;
		p_inc     = '0;

		if (acc) begin
			unique case (kind)
				REQ_WRITE: begin
					we = idx_ok;
				end
				REQ_START: begin
					if (!active_q) begin
						if (int'(req.data.msg_length) > BUF_DEPTH) begin
							len_d = DEPTH_P;
						end else begin
							len_d = PW'(req.data.msg_length);
						end
						status_d  = XS_PENDING;
						active_d  = 1'b1;
						cmd_valid = 1'b1;
						cmd_start = 1'b1;
						cmd_clr   = 1'b1;
					end
				end
				REQ_READ: begin
					rd_sel = idx_ok;
				end
				REQ_EVENT: begin
					if (active_q) begin
						case (stat) inside
							ST_START, ST_REP_START, ST_MTX_ADR_ACK, ST_MTX_DAT_ACK: begin
								// A START of either kind rewinds to the address byte.
								if (stat == ST_START || stat == ST_REP_START) begin
									p = '0;
								end
								cmd_valid = 1'b1;
								cmd_clr   = 1'b1;
								if (p < len_q && p < DEPTH_P) begin
									tx_load = 1'b1;
									raddr   = p[AW-1:0];
									ptr_d   = p + 1'b1;
								end else begin
									ptr_d     = p;
									cmd_stop  = 1'b1;
									status_d  = XS_SUCCESS;
									active_d  = 1'b0;
								end
							end
							ST_MRX_DAT_ACK, ST_MRX_ADR_ACK: begin
								// Data bytes are stored at the pointer, which then
								// advances; every byte but the last one is ACKed.
								if (stat == ST_MRX_DAT_ACK && ptr_q < DEPTH_P) begin
									we    = 1'b1;
									waddr = ptr_q[AW-1:0];
									wdata = req.data.rx_byte;
									p     = ptr_q + 1'b1;
								end
								ptr_d     = p;
								p_inc     = {1'b0, p} + 1'b1;
								cmd_valid = 1'b1;
								cmd_clr   = 1'b1;
								cmd_ack   = p_inc < {1'b0, len_q};
							end
							ST_MRX_DAT_NAK: begin
								// Final byte: store it and release the bus with STOP.
								we        = ptr_q < DEPTH_P;
								waddr     = ptr_q[AW-1:0];
								wdata     = req.data.rx_byte;
								status_d  = XS_SUCCESS;
								active_d  = 1'b0;
								cmd_valid = 1'b1;
								cmd_clr   = 1'b1;
								cmd_stop  = 1'b1;
							end
							ST_ARB_LOST: begin
								cmd_valid = 1'b1;
								cmd_clr   = 1'b1;
								cmd_start = 1'b1;
							end
							default: begin
								// Error events leave the flag set and disable the interrupt.
								unique case (stat)
									ST_MTX_ADR_NAK: status_d = XS_AW_NACK;
									ST_MRX_ADR_NAK: status_d = XS_AR_NACK;
									ST_MTX_DAT_NAK: status_d = XS_D_NACK;
									ST_BUS_ERR:     status_d = XS_BUS_ERR;
									default:        status_d = XS_OTHER;
								endcase
								active_d  = 1'b0;
								cmd_valid = 1'b1;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// A request never both reads and writes the buffer, and a read at one
	// edge sees every write made at earlier edges, so no forwarding is needed.
	assign re = tx_load || rd_sel;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			len_q       <= '0;
			status_q    <= XS_PENDING;
			active_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			ptr_q    <= ptr_d;
			len_q    <= len_d;
			status_q <= status_d;
			active_q <= active_d;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Status and busy are taken from the updated state of the same request.
	xfer_status_t status_s1;
	logic         busy_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_valid_s1 <= cmd_valid;
			cmd_start_s1 <= cmd_start;
			cmd_stop_s1  <= cmd_stop;
			cmd_ack_s1   <= cmd_ack;
			cmd_clr_s1   <= cmd_clr;
			tx_load_s1   <= tx_load;
			rd_sel_s1    <= rd_sel;
			status_s1    <= status_d;
			busy_s1      <= active_d;
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.data.cmd_valid      = cmd_valid_s1;
	assign rsp.data.cmd_start      = cmd_start_s1;
	assign rsp.data.cmd_stop       = cmd_stop_s1;
	assign rsp.data.cmd_ack        = cmd_ack_s1;
	assign rsp.data.cmd_clear_flag = cmd_clr_s1;
	assign rsp.data.tx_load        = tx_load_s1;
	assign rsp.data.tx_byte        = tx_load_s1 ? rdata_s1 : 8'h00;
	assign rsp.data.xfer_status    = status_s1;
	assign rsp.data.busy_res       = busy_s1;
	assign rsp.data.read_data      = rd_sel_s1 ? rdata_s1 : 8'h00;

	// A STOP always ends the transfer.
	a_stop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.cmd_stop |-> !rsp.data.busy_res)
		else $error("STOP issued while transfer still marked busy");

	// Without a command, no command bit may be set.
	a_cmd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.cmd_valid |-> !(rsp.data.cmd_start || rsp.data.cmd_stop
			|| rsp.data.cmd_ack || rsp.data.cmd_clear_flag || rsp.data.tx_load))
		else $error("command bits set without cmd_valid");

	// The pointer saturates at the buffer depth.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= DEPTH_P)
		else $error("byte pointer beyond buffer depth");

	// A start accepted while idle makes the block active.
	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		acc && kind == REQ_START && !active_q |=> active_q && status_q == XS_PENDING)
		else $error("start request did not activate the transfer");

	// Transmit loads and buffer reads never share a response.
	a_rd_tx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(tx_load_s1 && rd_sel_s1))
		else $error("tx load and buffer read in one response");

endmodule

[verif/i2cseq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cseq_checker
// Watches the request and response channels of the transfer sequencer, predicts
// the bus command for every accepted request and compares it with the response.
// ----------------------------------------------------------------------------
module i2cseq_checker #(
	parameter int BUF_DEPTH = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	i2cseq_req_if  req,
	i2cseq_rsp_if  rsp,
	output int     fail_count,
	output int     outstanding,
	output int     checked,
	output int     done_ok,
	output int     done_err
);
	import i2cseq_pkg::*;

	localparam int PW = $clog2(BUF_DEPTH + 1);

	// Shadow copy of the sequencer state.
	logic [7:0]   seq_buf [BUF_DEPTH];
	logic [PW-1:0] tx_ptr;
	logic [3:0]   xfer_len;
	xfer_status_t xfer_state;
	logic         busy;

	rsp_payload_t cmd_q [$];
	int           mismatches;
	int           n_checked;
	int           n_ok;
	int           n_err;

	// Computes the response to one request and advances the shadow state.
	function automatic rsp_payload_t next_command(input req_payload_t rq);
		rsp_payload_t r;
		logic [7:0]   code;
		r = '0;
		code = rq.bus_status & ST_MASK;
		case (rq.req_type)
			REQ_WRITE: begin
				if (rq.buf_index < BUF_DEPTH)
					seq_buf[rq.buf_index] = rq.buf_data;
			end
			REQ_START: begin
				if (!busy) begin
					xfer_len = (rq.msg_length > BUF_DEPTH) ? 4'(BUF_DEPTH) : rq.msg_length;
					xfer_state = XS_PENDING;
					busy = 1'b1;
					r.cmd_valid = 1'b1;
					r.cmd_start = 1'b1;
					r.cmd_clear_flag = 1'b1;
				end
			end
			REQ_READ: begin
				if (rq.buf_index < BUF_DEPTH)
					r.read_data = seq_buf[rq.buf_index];
			end
			default: begin
				if (busy) begin
					case (code)
						ST_START, ST_REP_START, ST_MTX_ADR_ACK, ST_MTX_DAT_ACK: begin
							if (code == ST_START || code == ST_REP_START)
								tx_ptr = '0;
							r.cmd_valid = 1'b1;
							r.cmd_clear_flag = 1'b1;
							if (tx_ptr < xfer_len && tx_ptr < BUF_DEPTH) begin
								r.tx_load = 1'b1;
								r.tx_byte = seq_buf[tx_ptr];
								tx_ptr = tx_ptr + 1'b1;
							end else begin
								r.cmd_stop = 1'b1;
								xfer_state = XS_SUCCESS;
								busy = 1'b0;
								n_ok++;
							end
						end
						ST_MRX_ADR_ACK, ST_MRX_DAT_ACK: begin
							if (code == ST_MRX_DAT_ACK && tx_ptr < BUF_DEPTH) begin
								seq_buf[tx_ptr] = rq.rx_byte;
								tx_ptr = tx_ptr + 1'b1;
							end
							r.cmd_valid = 1'b1;
							r.cmd_clear_flag = 1'b1;
							if (int'(tx_ptr) + 1 < int'(xfer_len))
								r.cmd_ack = 1'b1;
						end
						ST_MRX_DAT_NAK: begin
							if (tx_ptr < BUF_DEPTH)
								seq_buf[tx_ptr] = rq.rx_byte;
							xfer_state = XS_SUCCESS;
							busy = 1'b0;
							r.cmd_valid = 1'b1;
							r.cmd_clear_flag = 1'b1;
							r.cmd_stop = 1'b1;
							n_ok++;
						end
						ST_ARB_LOST: begin
							r.cmd_valid = 1'b1;
							r.cmd_clear_flag = 1'b1;
							r.cmd_start = 1'b1;
						end
						default: begin
							case (code)
								ST_MTX_ADR_NAK: xfer_state = XS_AW_NACK;
								ST_MRX_ADR_NAK: xfer_state = XS_AR_NACK;
								ST_MTX_DAT_NAK: xfer_state = XS_D_NACK;
								ST_BUS_ERR:     xfer_state = XS_BUS_ERR;
								default:        xfer_state = XS_OTHER;
							endcase
							busy = 1'b0;
							r.cmd_valid = 1'b1;
							n_err++;
						end
					endcase
				end
			end
		endcase
		r.xfer_status = xfer_state;
		r.busy_res = busy;
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("[%0t] mismatch on %s: expected 0x%0h, actual 0x%0h",
				$time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_payload_t want;
		if (!arst_n) begin
			tx_ptr = '0;
			xfer_len = '0;
			xfer_state = XS_PENDING;
			busy = 1'b0;
			for (int i = 0; i < BUF_DEPTH; i++)
				seq_buf[i] = '0;
			cmd_q.delete();
			mismatches = 0;
			n_checked = 0;
			n_ok = 0;
			n_err = 0;
		end else begin
			// The response taken now belongs to an earlier request, so compare first.
			if (rsp.valid && rsp.ready) begin
				if (cmd_q.size() == 0) begin
					$display("[%0t] unexpected response: expected none, actual 0x%0h",
						$time, rsp.data);
					mismatches++;
				end else begin
					want = cmd_q.pop_front();
					check_field("cmd_valid", want.cmd_valid, rsp.data.cmd_valid);
					check_field("cmd_start", want.cmd_start, rsp.data.cmd_start);
					check_field("cmd_stop", want.cmd_stop, rsp.data.cmd_stop);
					check_field("cmd_ack", want.cmd_ack, rsp.data.cmd_ack);
					check_field("cmd_clear_flag", want.cmd_clear_flag,
						rsp.data.cmd_clear_flag);
					check_field("tx_load", want.tx_load, rsp.data.tx_load);
					check_field("tx_byte", want.tx_byte, rsp.data.tx_byte);
					check_field("xfer_status", want.xfer_status, rsp.data.xfer_status);
					check_field("busy_res", want.busy_res, rsp.data.busy_res);
					check_field("read_data", want.read_data, rsp.data.read_data);
					n_checked++;
				end
			end
			if (req.valid && req.ready)
				cmd_q.push_back(next_command(req.data));
		end
		fail_count <= mismatches;
		outstanding <= cmd_q.size();
		checked <= n_checked;
		done_ok <= n_ok;
		done_err <= n_err;
	end

endmodule

[verif/tb_i2c_master_transfer_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer_core
// Drives buffer writes, transfer starts, bus status events and buffer reads into
// the sequencer with random gaps and response stalls; the checker beside the
// block predicts every response and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer_core;
	import i2cseq_pkg::*;

	localparam int BUF_DEPTH = 8;
	localparam int RANDOM_ITEMS = 1000;

	logic clk;
	logic arst_n;

	// When this is low both sides run back to back, with no gaps and no stalls.
	bit idle_on;
	int items_sent;

	int fail_count;
	int outstanding;
	int checked;
	int done_ok;
	int done_err;

	i2cseq_req_if req_ch ();
	i2cseq_rsp_if rsp_ch ();

	i2c_master_transfer_sequencer_core #(
		.BUF_DEPTH(BUF_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	i2cseq_checker #(
		.BUF_DEPTH(BUF_DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked(checked),
		.done_ok(done_ok),
		.done_err(done_err)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard stop in case a handshake never completes.
	initial begin
		#500000;
		$display("Test completed with failures");
		$finish;
	end

	// Every field gets a random value, so that the bits a request does not use
	// also toggle; callers overwrite the fields that matter.
	function automatic req_payload_t rand_payload();
		req_payload_t p;
		p.req_type = 2'($urandom_range(0, 3));
		p.buf_index = 3'($urandom_range(0, 7));
		p.buf_data = 8'($urandom_range(0, 255));
		p.msg_length = 4'($urandom_range(0, 15));
		p.bus_status = 8'($urandom_range(0, 255));
		p.rx_byte = 8'($urandom_range(0, 255));
		return p;
	endfunction

	// Mostly legal lengths, with zero and oversize lengths now and then.
	function automatic logic [3:0] pick_length();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 4'd0;
		if (roll == 1)
			return 4'($urandom_range(9, 15));
		return 4'($urandom_range(1, 8));
	endfunction

	// A status code that ends the transfer with an error. Unknown codes are
	// drawn from the gaps between the defined ones and from above them.
	function automatic logic [7:0] pick_error_code();
		case ($urandom_range(0, 5))
			0: return ST_MTX_ADR_NAK;
			1: return ST_MRX_ADR_NAK;
			2: return ST_MTX_DAT_NAK;
			3: return ST_BUS_ERR;
			4: return {5'($urandom_range(0, 11)), 1'b1, 2'b00};
			default: return 8'($urandom_range(8'h60, 8'hFF));
		endcase
	endfunction

	// Presents one request and returns at the edge where its transfer happens.
	// With a zero gap valid stays high straight into the next request.
	task automatic send_item(input req_payload_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= p;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic send_write(input logic [2:0] idx, input logic [7:0] value);
		req_payload_t p;
		p = rand_payload();
		p.req_type = REQ_WRITE;
		p.buf_index = idx;
		p.buf_data = value;
		send_item(p);
	endtask

	task automatic send_read(input logic [2:0] idx);
		req_payload_t p;
		p = rand_payload();
		p.req_type = REQ_READ;
		p.buf_index = idx;
		send_item(p);
	endtask

	task automatic send_start(input logic [3:0] len);
		req_payload_t p;
		p = rand_payload();
		p.req_type = REQ_START;
		p.msg_length = len;
		send_item(p);
	endtask

	// The low two bits of the bus status are don't-care, so they are random.
	task automatic send_event(input logic [7:0] code);
		req_payload_t p;
		p = rand_payload();
		p.req_type = REQ_EVENT;
		p.bus_status = code | 8'($urandom_range(0, 3));
		send_item(p);
	endtask

	// A master-transmit transfer: START loads the address byte, and each ACK
	// loads the next byte until the last ACK is answered with STOP. Now and then
	// arbitration is lost and the transfer starts over with a repeated START,
	// or it breaks off with an error code.
	task automatic run_write_transfer();
		int eff;
		int k;
		int restarts;
		int roll;
		repeat ($urandom_range(0, 3))
			send_write(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
		eff = pick_length();
		send_start(4'(eff));
		if (eff > BUF_DEPTH)
			eff = BUF_DEPTH;
		send_event(ST_START);
		k = 0;
		restarts = 0;
		while (k < eff) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				send_event(pick_error_code());
				return;
			end
			if (roll < 8 && restarts < 2) begin
				send_event(ST_ARB_LOST);
				send_event(ST_REP_START);
				restarts++;
				k = 0;
				continue;
			end
			send_event(k == 0 ? ST_MTX_ADR_ACK : ST_MTX_DAT_ACK);
			k++;
		end
	endtask

	// A master-receive transfer: address ACK, data bytes with ACK, and the last
	// byte with NACK. Sometimes extra data bytes run the pointer past the end of
	// the buffer, where received bytes are dropped.
	task automatic run_read_transfer();
		int eff;
		int steps;
		int k;
		int restarts;
		int roll;
		eff = pick_length();
		send_start(4'(eff));
		if (eff > BUF_DEPTH)
			eff = BUF_DEPTH;
		steps = (eff < 2) ? 2 : eff;
		if ($urandom_range(0, 9) == 0)
			steps += $urandom_range(1, 4);
		send_event(ST_START);
		k = 0;
		restarts = 0;
		while (k < steps) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				send_event(pick_error_code());
				return;
			end
			if (roll < 8 && restarts < 2) begin
				send_event(ST_ARB_LOST);
				send_event(ST_REP_START);
				restarts++;
				k = 0;
				continue;
			end
			if (k == 0)
				send_event(ST_MRX_ADR_ACK);
			else if (k == steps - 1)
				send_event(ST_MRX_DAT_NAK);
			else
				send_event(ST_MRX_DAT_ACK);
			k++;
		end
		if ($urandom_range(0, 3) == 0)
			send_read(3'($urandom_range(0, 7)));
	endtask

	// Response side: a random stall before each response is taken.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Request side, reset and verdict.
	initial begin
		int wait_cycles;
		logic [7:0] corner_bytes [8];
		corner_bytes = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
		items_sent = 0;
		idle_on = 1'b1;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Every buffer entry is written first, so that no later
		// read or transmit ever touches an entry that holds no defined byte.
		for (int i = 0; i < BUF_DEPTH; i++)
			send_write(3'(i), corner_bytes[i]);
		send_read(3'd0);
		send_read(3'd7);
		// An event while idle is ignored.
		send_event(ST_MTX_DAT_ACK);
		// A zero length transfer ends with STOP on its START event.
		send_start(4'd0);
		send_event(ST_START);
		// An oversize length is clamped; a second start while active is ignored.
		send_start(4'd15);
		send_start(4'd4);
		// Arbitration loss, repeated START, then an address NACK.
		send_event(ST_ARB_LOST);
		send_event(ST_REP_START);
		send_event(ST_MTX_ADR_NAK);
		// A short receive whose only data byte comes with NACK.
		send_start(4'd2);
		send_event(ST_START);
		send_event(ST_MRX_ADR_ACK);
		send_event(ST_MRX_DAT_NAK);
		send_read(3'd1);
		// An unknown status code ends a transfer with the catch-all error.
		send_start(4'd8);
		send_event(ST_START);
		send_event(8'hFC);

		// Random part: mostly well-formed transfers, with bursts of noise that
		// also hit events while idle and starts while a transfer runs.
		while (items_sent < 26 + RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: run_write_transfer();
				9, 10, 11, 12, 13, 14: run_read_transfer();
				default: begin
					repeat ($urandom_range(1, 4))
						send_item(rand_payload());
				end
			endcase
		end
		req_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (5) @(posedge clk);

		$display("Sent %0d requests and checked %0d responses.", items_sent, checked);
		$display("Transfers that ended with STOP: %0d, transfers that ended in error: %0d.",
			done_ok, done_err);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/i2cseq_pkg.sv
rtl/core/i2cseq_req_if.sv
rtl/core/i2cseq_rsp_if.sv
rtl/core/i2c_master_transfer_sequencer_core.sv
verif/i2cseq_checker.sv
verif/tb_i2c_master_transfer_sequencer_core.sv
